FILE: hdl/dqr_pkg.sv
`timescale 1ns / 1ps
// dqr_pkg: shared types and constants of the dns redirect responder
// no dependencies; imported by the core, front, queue and back modules

package dqr_pkg;

    localparam int MAX_QUERY_BYTES = 256;
    localparam int CNT_W           = $clog2(MAX_QUERY_BYTES + 1);
    localparam int HDR_LEN         = 12;
    localparam int ANS_LEN         = 16;
    localparam int IDX_W           = $clog2(ANS_LEN);

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // header positions that are checked or rewritten
    localparam logic [IDX_W-1:0] POS_FLAGS_HI   = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_FLAGS_LO   = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_ANCOUNT_HI = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_ANCOUNT_LO = IDX_W'(7);

    // flag bytes of a standard query and of the response
    localparam logic [7:0] QUERY_FLAGS_HI = 8'h01;
    localparam logic [7:0] QUERY_FLAGS_LO = 8'h00;
    localparam logic [7:0] RESP_FLAGS_HI  = 8'h81;
    localparam logic [7:0] RESP_FLAGS_LO  = 8'h80;
    localparam logic [7:0] ANCOUNT_HI     = 8'h00;
    localparam logic [7:0] ANCOUNT_LO     = 8'h01;

    // answer record bytes
    localparam logic [7:0] NAME_PTR_HI = 8'hC0;
    localparam logic [7:0] NAME_PTR_LO = 8'h0C;
    localparam logic [7:0] TYPE_A_HI   = 8'h00;
    localparam logic [7:0] TYPE_A_LO   = 8'h01;
    localparam logic [7:0] CLASS_IN_HI = 8'h00;
    localparam logic [7:0] CLASS_IN_LO = 8'h01;
    localparam logic [7:0] RDLEN_HI    = 8'h00;
    localparam logic [7:0] RDLEN_LO    = 8'h04;

    // register reset values
    localparam logic [31:0] RESET_PORTAL = 32'hC0A8_0401;
    localparam logic [31:0] RESET_TTL    = 32'h0000_012C;

    typedef enum logic {
        REG_PORTAL = 1'b0,
        REG_TTL    = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_STORE,
        CMD_HEADER,
        CMD_BODY,
        CMD_ANSWER
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic             ans;
    } cmd_t;

    typedef struct packed {
        logic [31:0] portal_address;
        logic [31:0] answer_ttl;
    } cfg_t;

endpackage

FILE: hdl/dns_query_redirect_responder_core.sv
`timescale 1ns / 1ps
// dns_query_redirect_responder_core: top level of the dns redirect responder
// query byte channel in, response byte channel out, apb register port
// depends on dqr_pkg, dqr_front, dqr_cmd_fifo and dqr_back
//
// usage
//   query bytes enter on in_valid/in_ready with in_last on the final byte;
//   response bytes leave on out_valid/out_ready with out_last on the final
//   byte of the appended answer record. both sides transfer when valid and
//   ready are high at a clock edge.
//   the front takes one byte per cycle while the 4-entry command queue has
//   room. with the queue empty, a body byte passes through the queue and
//   then the output register before it appears on the output.
//   the twelfth byte of a standard query opens a 12-byte header burst and
//   the final byte a 16-byte answer burst; the back emits one byte per
//   cycle while the receiver is ready, so a burst holds the input once the
//   queue fills. the back emits through an output register, one byte per
//   cycle while out_ready allows, limited by the single output port.
//   reset (rst_n low, asynchronous) empties the queue, clears the byte count
//   and drop state, and loads portal_address 192.168.4.1 and answer_ttl 300.
//   when the receiver stalls, the output byte holds, the back stops, and the
//   queue then fills and drops in_ready.
//   registers: portal_address at 0x0, answer_ttl at 0x4; write only while
//   no datagram is in flight

module dns_query_redirect_responder_core
    import dqr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // query channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    // response channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] portal_address_reg;
    logic [31:0] portal_address_next;
    logic [31:0] answer_ttl_reg;
    logic [31:0] answer_ttl_next;
    logic        cfg_wr;
    reg_idx_t    reg_sel;
    cfg_t        cfg;

    // command queue wiring
    logic        push;
    cmd_t        push_cmd;
    logic        q_full;
    logic        pop;
    logic        q_valid;
    cmd_t        q_cmd;

    // register port: write lands in the access phase, reads are immediate
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_comb
    begin
        portal_address_next = portal_address_reg;
        answer_ttl_next     = answer_ttl_reg;
        unique case (reg_sel)
            REG_PORTAL:
            begin
                prdata = portal_address_reg;
                if (cfg_wr)
                begin
                    portal_address_next = pwdata;
                end
            end
            REG_TTL:
            begin
                prdata = answer_ttl_reg;
                if (cfg_wr)
                begin
                    answer_ttl_next = pwdata;
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            portal_address_reg <= RESET_PORTAL;
            answer_ttl_reg     <= RESET_TTL;
        end
        else
        begin
            portal_address_reg <= portal_address_next;
            answer_ttl_reg     <= answer_ttl_next;
        end
    end

    assign cfg.portal_address = portal_address_reg;
    assign cfg.answer_ttl     = answer_ttl_reg;

    // front: byte count, header check, one command per byte at most
    dqr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decouples the byte-rate front from the bursty back
    dqr_cmd_fifo u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // back: header store, header and answer bursts, output register
    dqr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

FILE: hdl/dqr_cmd_fifo.sv
`timescale 1ns / 1ps
// dqr_cmd_fifo: short command queue between front and back
// depends on dqr_pkg for cmd_t and the queue depth

module dqr_cmd_fifo
    import dqr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    cmd_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/dqr_front.sv
`timescale 1ns / 1ps
// dqr_front: takes query bytes, counts them, checks the header flags
// and turns each byte into at most one command; depends on dqr_pkg

module dqr_front
    import dqr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic             drop_reg;
    logic             drop_next;
    logic             hdr_ok_reg;
    logic             hdr_ok_next;
    logic             accept;
    logic             cnt_open;
    logic             in_hdr;
    logic             at_check;
    logic [IDX_W-1:0] hdr_idx;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cnt_open = (byte_count_reg < CNT_W'(MAX_QUERY_BYTES));
    assign in_hdr   = (byte_count_reg < CNT_W'(HDR_LEN - 1));
    assign at_check = (byte_count_reg == CNT_W'(HDR_LEN - 1));
    assign hdr_idx  = byte_count_reg[IDX_W-1:0];

    always_comb
    begin
        byte_count_next = byte_count_reg;
        drop_next       = drop_reg;
        hdr_ok_next     = hdr_ok_reg;
        push            = 1'b0;
        push_cmd.kind   = CMD_STORE;
        push_cmd.idx    = hdr_idx;
        push_cmd.data   = in_byte;
        push_cmd.ans    = in_last;
        if (accept)
        begin
            if (cnt_open)
            begin
                byte_count_next = byte_count_reg + 1'b1;
                if (in_hdr)
                begin
                    push = 1'b1;
                    if (hdr_idx == POS_FLAGS_HI)
                    begin
                        hdr_ok_next = (in_byte == QUERY_FLAGS_HI);
                    end
                    if (hdr_idx == POS_FLAGS_LO)
                    begin
                        hdr_ok_next = hdr_ok_reg && (in_byte == QUERY_FLAGS_LO);
                    end
                end
                else if (at_check)
                begin
                    // twelfth byte: header passes or the datagram is dropped
                    if (hdr_ok_reg)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_HEADER;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                else if (!drop_reg)
                begin
                    push          = 1'b1;
                    push_cmd.kind = CMD_BODY;
                end
            end
            else if (in_last && !drop_reg)
            begin
                // truncated tail, only the answer remains
                push          = 1'b1;
                push_cmd.kind = CMD_ANSWER;
            end
            if (in_last)
            begin
                byte_count_next = '0;
                drop_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            drop_reg       <= 1'b0;
            hdr_ok_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            drop_reg       <= drop_next;
            hdr_ok_reg     <= hdr_ok_next;
        end
    end

endmodule

FILE: hdl/dqr_back.sv
`timescale 1ns / 1ps
// dqr_back: carries out queued commands, holds the header store and
// drives the output register; depends on dqr_pkg

module dqr_back
    import dqr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       pop,
    input  cfg_t       cfg,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_ANS
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             ans_pend_reg;
    logic             ans_pend_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             out_last_reg;
    logic             out_last_next;
    logic [7:0]       header_store [HDR_LEN];
    logic             store_wr;
    logic             slot_free;
    logic             emit;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic [7:0]       hdr_byte;
    logic [7:0]       ans_byte;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // header byte with flags and answer count rewritten
    always_comb
    begin
        unique case (cnt_reg)
            POS_FLAGS_HI:   hdr_byte = RESP_FLAGS_HI;
            POS_FLAGS_LO:   hdr_byte = RESP_FLAGS_LO;
            POS_ANCOUNT_HI: hdr_byte = ANCOUNT_HI;
            POS_ANCOUNT_LO: hdr_byte = ANCOUNT_LO;
            default:        hdr_byte = header_store[cnt_reg];
        endcase
    end

    always_comb
    begin
        unique case (cnt_reg)
            IDX_W'(0):  ans_byte = NAME_PTR_HI;
            IDX_W'(1):  ans_byte = NAME_PTR_LO;
            IDX_W'(2):  ans_byte = TYPE_A_HI;
            IDX_W'(3):  ans_byte = TYPE_A_LO;
            IDX_W'(4):  ans_byte = CLASS_IN_HI;
            IDX_W'(5):  ans_byte = CLASS_IN_LO;
            IDX_W'(6):  ans_byte = cfg.answer_ttl[31:24];
            IDX_W'(7):  ans_byte = cfg.answer_ttl[23:16];
            IDX_W'(8):  ans_byte = cfg.answer_ttl[15:8];
            IDX_W'(9):  ans_byte = cfg.answer_ttl[7:0];
            IDX_W'(10): ans_byte = RDLEN_HI;
            IDX_W'(11): ans_byte = RDLEN_LO;
            IDX_W'(12): ans_byte = cfg.portal_address[31:24];
            IDX_W'(13): ans_byte = cfg.portal_address[23:16];
            IDX_W'(14): ans_byte = cfg.portal_address[15:8];
            default:    ans_byte = cfg.portal_address[7:0];
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ans_pend_next = ans_pend_reg;
        pop           = 1'b0;
        store_wr      = 1'b0;
        emit          = 1'b0;
        emit_byte     = q_cmd.data;
        emit_last     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_cmd.kind)
                        CMD_STORE:
                        begin
                            pop      = 1'b1;
                            store_wr = 1'b1;
                        end
                        CMD_HEADER:
                        begin
                            pop           = 1'b1;
                            store_wr      = 1'b1;
                            state_next    = ST_HDR;
                            cnt_next      = '0;
                            ans_pend_next = q_cmd.ans;
                        end
                        CMD_BODY:
                        begin
                            if (slot_free)
                            begin
                                pop  = 1'b1;
                                emit = 1'b1;
                                if (q_cmd.ans)
                                begin
                                    state_next = ST_ANS;
                                    cnt_next   = '0;
                                end
                            end
                        end
                        CMD_ANSWER:
                        begin
                            pop        = 1'b1;
                            state_next = ST_ANS;
                            cnt_next   = '0;
                        end
                        default:
                        begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_HDR:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = hdr_byte;
                    if (cnt_reg == IDX_W'(HDR_LEN - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ans_pend_reg ? ST_ANS : ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_ANS:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_byte = ans_byte;
                    if (cnt_reg == IDX_W'(ANS_LEN - 1))
                    begin
                        emit_last  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (slot_free)
        begin
            out_valid_next = emit;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ans_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ans_pend_reg  <= ans_pend_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

    // header store, no reset: each entry is written before it is read
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            header_store[q_cmd.idx] <= q_cmd.data;
        end
    end

endmodule

FILE: hdl/dqr_checker.sv
`timescale 1ns / 1ps
// dqr_checker: port-level assertions for the dns redirect responder
// no package dependency; bound to dns_query_redirect_responder_core below

module dqr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       pready
);

    // a stalled response byte holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("response byte changed while stalled");

    // nothing leaves once reset has been applied
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("response valid during reset");

    // an answer record is 16 bytes, so two final bytes never follow each other
    a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !(out_valid && out_last))
        else $error("final response bytes back to back");

    // register port never inserts wait states
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("register port stalled");

endmodule

bind dns_query_redirect_responder_core dqr_checker u_dqr_checker (.*);

FILE: sim/dns_query_redirect_responder_core_tb.sv
`timescale 1ns / 1ps
// dns_query_redirect_responder_core_tb: self-checking bench for the dns redirect responder
// a directed table of query shapes, then randomized query traffic in three pacing phases
// depends on dqr_pkg and dns_query_redirect_responder_core

module dns_query_redirect_responder_core_tb;
    import dqr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PHASE_BUDGET  = 24;
    localparam int          LONG_HOLD     = 300;
    localparam int          LONG_QUERY    = 260;

    // how the header and body bytes of a query are filled
    typedef enum {
        FILL_ZERO,
        FILL_ONES,
        FILL_RAND
    } fill_kind_t;

    // one directed query: length, flag bytes, fill and, where obvious, the response length
    typedef struct {
        int         len;
        logic [7:0] flags_hi;
        logic [7:0] flags_lo;
        fill_kind_t fill;
        int         resp_len;   // -1: left to the predictor alone
    } query_shape_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } resp_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = 8'h00;
    logic        in_last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state: its own copy of the header, count, drop state and registers
    logic [7:0]        hdr_copy [HDR_LEN];
    logic [CNT_W-1:0]  query_count = '0;
    logic              dropping = 1'b0;
    logic [31:0]       portal_copy = 32'hC0A8_0401;
    logic [31:0]       ttl_copy = 32'd300;

    // response bytes predicted but not yet seen on the output
    resp_byte_t  pending_resp [$];

    int unsigned cycle_count = 0;
    int          fail_count = 0;
    int          resp_seen = 0;
    int          bytes_sent = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        long_hold_req = 1'b0;
    int          hold_left = 0;

    // directed shapes: reset registers, twelfth byte final, short and wrong-header drops
    // and byte extremes
    query_shape_t directed_rows [10] = '{
        '{ 12, 8'h01, 8'h00, FILL_ZERO,  28},
        '{ 11, 8'h01, 8'h00, FILL_ONES,   0},
        '{  1, 8'h01, 8'h00, FILL_ZERO,   0},
        '{ 12, 8'h81, 8'h80, FILL_ONES,   0},
        '{ 13, 8'h01, 8'h01, FILL_ZERO,   0},
        '{ 13, 8'h00, 8'h00, FILL_RAND,   0},
        '{ 14, 8'h01, 8'h00, FILL_ONES,  30},
        '{ 13, 8'h01, 8'h00, FILL_RAND,  29},
        '{ 12, 8'hFF, 8'hFF, FILL_ONES,   0},
        '{ 15, 8'h01, 8'h00, FILL_RAND,  -1}
    };

    dns_query_redirect_responder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // hard stop on a hang
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still pending",
                     cycle_count, pending_resp.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        fail_count++;
    endtask

    function automatic void push_resp(input logic [7:0] data, input logic last);
        resp_byte_t r;
        r.data = data;
        r.last = last;
        pending_resp.push_back(r);
    endfunction

    // predictor: one accepted query byte in, the response bytes it causes queued
    function automatic void absorb_query_byte(input logic [7:0] data, input logic last);
        int         pos;
        logic [7:0] ans [ANS_LEN];
        logic [7:0] hb;
        if (query_count < MAX_QUERY_BYTES)
        begin
            pos = query_count;
            query_count = query_count + 1'b1;
            if (pos < HDR_LEN)
            begin
                hdr_copy[pos] = data;
                // twelfth byte: check the flags, then the rewritten header goes out whole
                if (pos == HDR_LEN - 1)
                begin
                    if (hdr_copy[POS_FLAGS_HI] != QUERY_FLAGS_HI
                        || hdr_copy[POS_FLAGS_LO] != QUERY_FLAGS_LO)
                        dropping = 1'b1;
                    else
                    begin
                        for (int i = 0; i < HDR_LEN; i++)
                        begin
                            hb = hdr_copy[i];
                            if (i == POS_FLAGS_HI)        hb = RESP_FLAGS_HI;
                            else if (i == POS_FLAGS_LO)   hb = RESP_FLAGS_LO;
                            else if (i == POS_ANCOUNT_HI) hb = ANCOUNT_HI;
                            else if (i == POS_ANCOUNT_LO) hb = ANCOUNT_LO;
                            push_resp(hb, 1'b0);
                        end
                    end
                end
            end
            else if (!dropping)
                push_resp(data, 1'b0);
        end
        if (last)
        begin
            if (query_count >= HDR_LEN && !dropping)
            begin
                ans[0]  = NAME_PTR_HI;        ans[1]  = NAME_PTR_LO;
                ans[2]  = TYPE_A_HI;          ans[3]  = TYPE_A_LO;
                ans[4]  = CLASS_IN_HI;        ans[5]  = CLASS_IN_LO;
                ans[6]  = ttl_copy[31:24];    ans[7]  = ttl_copy[23:16];
                ans[8]  = ttl_copy[15:8];     ans[9]  = ttl_copy[7:0];
                ans[10] = RDLEN_HI;           ans[11] = RDLEN_LO;
                ans[12] = portal_copy[31:24]; ans[13] = portal_copy[23:16];
                ans[14] = portal_copy[15:8];  ans[15] = portal_copy[7:0];
                for (int i = 0; i < ANS_LEN; i++)
                    push_resp(ans[i], i == ANS_LEN - 1);
            end
            query_count = '0;
            dropping = 1'b0;
        end
    endfunction

    // response checker: every output transfer against the oldest pending byte
    always @(posedge clk)
    begin
        resp_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            resp_seen++;
            if (pending_resp.size() == 0)
                report_mismatch("response byte with nothing pending", out_byte, 0);
            else
            begin
                want = pending_resp.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (out_last !== want.last)
                    report_mismatch("out_last", out_last, want.last);
            end
        end
    end

    // receiver pacing; a long hold-off is counted down here once requested
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // register write: setup cycle, access cycle, then the bus goes idle
    task automatic set_register(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PORTAL)
            portal_copy = value;
        else
            ttl_copy = value;
        @(posedge clk);
    endtask

    // register read-back, sampled mid access cycle
    task automatic check_register(input reg_idx_t idx);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_PORTAL && got !== portal_copy)
            report_mismatch("portal_address read", got, portal_copy);
        if (idx == REG_TTL && got !== ttl_copy)
            report_mismatch("answer_ttl read", got, ttl_copy);
        @(posedge clk);
    endtask

    // one query byte: optional idle gap, then offer until the transfer
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= data;
        in_last  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        absorb_query_byte(data, last);
    endtask

    task automatic send_query(input int len, input logic [7:0] fhi, input logic [7:0] flo,
                              input fill_kind_t fill);
        logic [7:0] data;
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO: data = 8'h00;
                FILL_ONES: data = 8'hFF;
                default:   data = 8'($urandom);
            endcase
            if (i == POS_FLAGS_HI)
                data = fhi;
            else if (i == POS_FLAGS_LO)
                data = flo;
            send_byte(data, i == len - 1);
        end
    endtask

    // stop offering, wait for every pending byte, then let the block settle
    task automatic drain_responses();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random traffic: mostly well-formed queries, some short, wrong-header and noise
    task automatic run_random_phase(input int budget);
        int         start;
        int         pick;
        logic [7:0] fhi;
        logic [7:0] flo;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            pick = $urandom_range(99);
            fhi = 8'($urandom);
            flo = 8'($urandom);
            if (pick < 70)
                send_query($urandom_range(40, 12), QUERY_FLAGS_HI, QUERY_FLAGS_LO, FILL_RAND);
            else if (pick < 80)
                send_query($urandom_range(11, 1), QUERY_FLAGS_HI, QUERY_FLAGS_LO, FILL_RAND);
            else if (pick < 90)
            begin
                if (fhi == QUERY_FLAGS_HI && flo == QUERY_FLAGS_LO)
                    flo = ~flo;
                send_query($urandom_range(40, 12), fhi, flo, FILL_RAND);
            end
            else
                send_query($urandom_range(40, 1), fhi, flo, FILL_RAND);
        end
        drain_responses();
    endtask

    initial
    begin
        int seen0;
        for (int i = 0; i < HDR_LEN; i++)
            hdr_copy[i] = 8'h00;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers come up at their reset values
        check_register(REG_PORTAL);
        check_register(REG_TTL);

        // directed table, one query at a time, no idling
        foreach (directed_rows[r])
        begin
            seen0 = resp_seen;
            send_query(directed_rows[r].len, directed_rows[r].flags_hi,
                       directed_rows[r].flags_lo, directed_rows[r].fill);
            drain_responses();
            if (directed_rows[r].resp_len >= 0 && resp_seen - seen0 != directed_rows[r].resp_len)
                report_mismatch("response length", resp_seen - seen0, directed_rows[r].resp_len);
        end

        // phase one: sender idles lightly, receiver heavily; extreme register values
        set_register(REG_PORTAL, 32'h0000_0000);
        set_register(REG_TTL, 32'hFFFF_FFFF);
        check_register(REG_PORTAL);
        check_register(REG_TTL);
        tx_idle_pct = 27;
        rx_idle_pct = 56;
        run_random_phase(PHASE_BUDGET);

        // phase two: the other way round, opposite extremes
        set_register(REG_PORTAL, 32'hFFFF_FFFF);
        set_register(REG_TTL, 32'h0000_0000);
        check_register(REG_PORTAL);
        check_register(REG_TTL);
        tx_idle_pct = 56;
        rx_idle_pct = 27;
        run_random_phase(PHASE_BUDGET);

        // phase three: no idling; a long receiver hold-off while a query past the
        // truncation length streams in, so the command queue fills and in_ready drops
        set_register(REG_PORTAL, $urandom);
        set_register(REG_TTL, $urandom);
        check_register(REG_PORTAL);
        check_register(REG_TTL);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_hold_req = 1'b1;
        send_query(LONG_QUERY, QUERY_FLAGS_HI, QUERY_FLAGS_LO, FILL_RAND);
        drain_responses();

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
